/* src/assert_macros.svh */
// Assertion macros shared by the group decoder RTL.
// Relies on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define TGD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tgd assertion failed");
// Check that a condition never holds outside reset.
`define TGD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tgd forbidden condition seen");
`else
`define TGD_ASSERT(label, prop)
`define TGD_ASSERT_NEVER(label, cond)
`endif
`endif

/* src/tgd_pkg.sv */
// Shared types, constants and helpers for the text group decoder.
// No dependencies; imported by every module of the block.
package tgd_pkg;

  localparam int SECTORS_PER_TRACK = 26;
  localparam int GROUP_CHARS       = 10;
  localparam int GROUP_BYTES       = 8;
  localparam int HEADER_BYTES      = 16;
  localparam int DESC_DEPTH        = 4;
  localparam int DESC_PTR_W        = $clog2(DESC_DEPTH);
  localparam int DESC_CNT_W        = $clog2(DESC_DEPTH + 1);

  localparam logic [4:0] SECTOR_LAST = 5'(SECTORS_PER_TRACK);
  localparam logic [7:0] SPT_LO      = 8'(SECTORS_PER_TRACK & 'hff);
  localparam logic [7:0] SPT_HI      = 8'((SECTORS_PER_TRACK >> 8) & 'hff);
  localparam logic [3:0] LAST_CHAR   = 4'(GROUP_CHARS - 1);

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } byte_kind_e;

  // One decoded group as handed from the front to the back.
  typedef struct packed {
    logic            hdr;
    logic            err;
    logic [7:0]      track;
    logic            side;
    logic [4:0]      sector;
    logic [7:0][7:0] data;
  } group_desc_t;

  function automatic logic [7:0] unshift(input logic [7:0] c);
    logic [7:0] t;
    t = c - 8'd32;
    if (t[7]) t = t - 8'd50;
    return t;
  endfunction

  function automatic logic [7:0] header_byte(input logic [3:0] idx,
                                             input logic [7:0] track,
                                             input logic       side,
                                             input logic [4:0] sector);
    logic [7:0] b;
    case (idx)
      4'd0:    b = track;
      4'd1:    b = {7'd0, side};
      4'd2:    b = {3'd0, sector};
      4'd3:    b = 8'd1;
      4'd4:    b = SPT_LO;
      4'd5:    b = SPT_HI;
      4'd15:   b = 8'd1;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

/* src/tgd_front.sv */
// Front end: collects characters, decodes each group and steps sector state.
// Depends on tgd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tgd_front import tgd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [7:0]  char_code_i,
  output logic        full_o,
  input  logic        mode_i,
  input  logic        desc_full_i,
  output logic        desc_push_o,
  output group_desc_t desc_o
);

  logic [3:0] cnt_q, cnt_d;
  logic [5:0] sum_q, sum_d;
  logic [7:0] tbuf_q [9];
  logic [4:0] gis_q, gis_d;
  logic [7:0] track_q, track_d;
  logic       side_q, side_d;
  logic [4:0] sector_q, sector_d;
  logic       stopped_q, stopped_d;

  logic       accept, complete, hdr, ok;
  logic [7:0] t_cur;
  logic [4:0] sector_inc;

  assign full_o   = !stopped_q && (cnt_q == LAST_CHAR) && desc_full_i;
  assign accept   = push_i && !full_o && !stopped_q;
  assign complete = accept && (cnt_q == LAST_CHAR);
  assign t_cur    = unshift(char_code_i);
  assign hdr      = mode_i && (gis_q == 5'd0);
  assign ok       = ({1'b0, sum_q} == t_cur[7:1]);
  assign sector_inc = sector_q + 5'd1;

  always_comb begin
    desc_o.hdr    = hdr;
    desc_o.err    = !ok;
    desc_o.track  = track_q;
    desc_o.side   = side_q;
    desc_o.sector = sector_q;
    desc_o.data[0] = {tbuf_q[0][7] | t_cur[0], tbuf_q[0][6:0]};
    for (int i = 1; i < GROUP_BYTES; i++) begin
      desc_o.data[i] = {tbuf_q[i][7] | tbuf_q[8][7-i], tbuf_q[i][6:0]};
    end
  end
  assign desc_push_o = complete;

  always_comb begin
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    gis_d     = gis_q;
    track_d   = track_q;
    side_d    = side_q;
    sector_d  = sector_q;
    stopped_d = stopped_q;
    if (accept) begin
      if (cnt_q == 4'd0) begin
        sum_d = t_cur[5:0];
      end else if (cnt_q < 4'(GROUP_BYTES)) begin
        sum_d = sum_q + t_cur[5:0];
      end
      if (complete) begin
        cnt_d = 4'd0;
        if (hdr) begin
          // Step to the next sector; wrap to a new side, then a new track.
          if (sector_inc > SECTOR_LAST || sector_inc == 5'd0) begin
            sector_d = 5'd1;
            side_d   = !side_q;
            if (side_q) track_d = track_q + 8'd1;
          end else begin
            sector_d = sector_inc;
          end
        end
        if (!ok) stopped_d = 1'b1;
        else if (mode_i) gis_d = gis_q + 5'd1;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 4'd0;
      sum_q     <= 6'd0;
      gis_q     <= 5'd0;
      track_q   <= 8'd0;
      side_q    <= 1'b0;
      sector_q  <= 5'd1;
      stopped_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      gis_q     <= gis_d;
      track_q   <= track_d;
      side_q    <= side_d;
      sector_q  <= sector_d;
      stopped_q <= stopped_d;
    end
  end

  // Character buffer: written in place, no reset needed.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      if (accept && cnt_q == 4'(i)) tbuf_q[i] <= t_cur;
    end
  end

  `TGD_ASSERT(a_no_push_stopped, stopped_q |-> !desc_push_o)
  `TGD_ASSERT(a_full_only_at_end, full_o |-> (cnt_q == LAST_CHAR))
  `TGD_ASSERT(a_stop_sticks, $past(stopped_q) |-> stopped_q)

endmodule

/* src/tgd_desc_fifo.sv */
// Short queue of decoded groups between front and back.
// Depends on tgd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tgd_desc_fifo import tgd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  group_desc_t desc_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        avail_o,
  output group_desc_t head_o
);

  group_desc_t             mem_q [DESC_DEPTH];
  logic [DESC_PTR_W-1:0]   wptr_q, rptr_q;
  logic [DESC_CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == DESC_CNT_W'(DESC_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + DESC_PTR_W'(1);
      if (pop_i)  rptr_q <= rptr_q + DESC_PTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + DESC_CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - DESC_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= desc_i;
  end

  `TGD_ASSERT_NEVER(a_push_full, push_i && full_o)
  `TGD_ASSERT_NEVER(a_pop_empty, pop_i && !avail_o)

endmodule

/* src/tgd_back.sv */
// Back end: walks each queued group byte by byte into the output register.
// Depends on tgd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tgd_back import tgd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  group_desc_t head_i,
  output logic        desc_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  byte_kind_o,
  output logic        last_of_group_o
);

  logic [4:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] byte_q;
  byte_kind_e kind_q;
  logic       last_q;

  logic       slot_free, step, in_hdr, last;
  logic [7:0] cur_byte;
  byte_kind_e cur_kind;

  assign slot_free = !ovalid_q || pop_i;
  assign step      = avail_i && slot_free;
  assign in_hdr    = head_i.hdr && !idx_q[4];

  always_comb begin
    if (in_hdr) begin
      cur_byte = header_byte(idx_q[3:0], head_i.track, head_i.side, head_i.sector);
      cur_kind = KIND_HEADER;
      last     = 1'b0;
    end else if (head_i.err) begin
      cur_byte = 8'd0;
      cur_kind = KIND_ERROR;
      last     = 1'b1;
    end else begin
      cur_byte = head_i.data[idx_q[2:0]];
      cur_kind = KIND_DATA;
      last     = (idx_q[2:0] == 3'(GROUP_BYTES - 1));
    end
  end

  assign desc_pop_o = step && last;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (pop_i) ovalid_d = 1'b0;
    if (step) begin
      ovalid_d = 1'b1;
      idx_d    = last ? 5'd0 : idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 5'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= cur_byte;
      kind_q <= cur_kind;
      last_q <= last;
    end
  end

  assign empty_o         = !ovalid_q;
  assign out_byte_o      = byte_q;
  assign byte_kind_o     = kind_q;
  assign last_of_group_o = last_q;

  `TGD_ASSERT(a_last_not_hdr, (ovalid_q && last_q) |-> (kind_q != KIND_HEADER))
  `TGD_ASSERT(a_idx_bound, idx_q < 5'(HEADER_BYTES + GROUP_BYTES))

endmodule

/* src/text_group_decoder_sector_framer_core.sv */
// Top level of the text group decoder with optional sector framing.
// Depends on tgd_pkg, tgd_front, tgd_desc_fifo and tgd_back.
//
// Usage:
//   Input queue: drive char_code_i and push; a character is taken on a
//   clock edge with push high and full low. Ten characters form a group.
//   Result queue: while empty is low the oldest word sits on out_byte_o,
//   byte_kind_o and last_of_group_o; pop high on an edge takes it.
//   Config: cfg_data_i sets framing mode (0 plain, 1 sector headers) on an
//   edge with cfg_valid_i high; cfg_ready_o is always high. The mode is
//   sampled when a group completes; write it only while idle.
// Timing: one character per cycle in while full is low. The first word of a
//   group passes the group queue and the output register once its tenth
//   character is taken; while pop keeps up, the back end sequencer sends
//   one word per cycle: 8 data words, 16 header words first when a sector
//   starts, or a single error word. A four-entry group queue soaks up headers.
// Stall: when the receiver holds off, the group queue fills and full rises
//   only on the tenth character of a group. After a checksum error the block
//   accepts and drops all characters until reset.
// Reset: asynchronous, active low; clears counters, mode, sector position
//   (track 0, side 0, sector 1) and both queues. No clearing pass.
module text_group_decoder_sector_framer_core import tgd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic [7:0] char_code_i,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [1:0] byte_kind_o,
  output logic       last_of_group_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic        mode_q;
  logic        desc_full, desc_push, desc_pop, desc_avail;
  group_desc_t desc_in, desc_head;

  // Framing mode register: always ready; write it only while idle (not enforced).
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Collect and decode groups, step sector numbering.
  tgd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .char_code_i (char_code_i),
    .full_o      (full),
    .mode_i      (mode_q),
    .desc_full_i (desc_full),
    .desc_push_o (desc_push),
    .desc_o      (desc_in)
  );

  // Hold decoded groups so front and back stall independently.
  tgd_desc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (desc_in),
    .full_o  (desc_full),
    .pop_i   (desc_pop),
    .avail_o (desc_avail),
    .head_o  (desc_head)
  );

  // Serialize each group into result words.
  tgd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (desc_avail),
    .head_i          (desc_head),
    .desc_pop_o      (desc_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .out_byte_o      (out_byte_o),
    .byte_kind_o     (byte_kind_o),
    .last_of_group_o (last_of_group_o)
  );

endmodule
